### sv/bhd_pkg.sv
// Package for the batch Hamming distance block: sizes, limits, payload types
// and the population count function.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package bhd_pkg;

	// Query store depth and derived widths
	localparam int MAX_WORDS = 16;
	localparam int POS_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CNT_W     = $clog2(MAX_WORDS + 1);

	// Field widths fixed by the interface
	localparam int WORD_W = 64;
	localparam int WPS_W  = 5;
	localparam int DIST_W = 11;
	localparam int ONES_W = $clog2(WORD_W + 1);

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [WPS_W-1:0]  WPS_RESET = WPS_W'(1);

	localparam logic MODE_QUERY  = 1'b0;
	localparam logic MODE_RECORD = 1'b1;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Control carried with a record word into the accumulate stage
	typedef struct packed {
		logic first;        // first word of a record: sum starts from zero
		logic last_word;    // last word of a record: a result goes out
		logic final_record; // batch-end mark echoed on the result
	} s1_ctrl_t;

	// Number of set bits in one 64-bit signature word, as an adder tree:
	// nibble counts, then pairwise sums down to one total
	function automatic logic [ONES_W-1:0] ones_in_word(input logic [WORD_W-1:0] w);
		logic [2:0] n4  [16];
		logic [3:0] n8  [8];
		logic [4:0] n16 [4];
		logic [5:0] n32 [2];
		for (int i = 0; i < 16; i++) begin
			n4[i] = 3'(w[4*i]) + 3'(w[4*i+1]) + 3'(w[4*i+2]) + 3'(w[4*i+3]);
		end
		for (int i = 0; i < 8; i++) begin
			n8[i] = 4'(n4[2*i]) + 4'(n4[2*i+1]);
		end
		for (int i = 0; i < 4; i++) begin
			n16[i] = 5'(n8[2*i]) + 5'(n8[2*i+1]);
		end
		for (int i = 0; i < 2; i++) begin
			n32[i] = 6'(n16[2*i]) + 6'(n16[2*i+1]);
		end
		return ONES_W'(n32[0]) + ONES_W'(n32[1]);
	endfunction

endpackage

`default_nettype wire

### sv/bhd_ifs.sv
// Valid/ready channel interfaces of the batch Hamming distance block:
// signature word requests, distance results and the configuration write.
// Depends on bhd_pkg for field widths.
`default_nettype none

interface bhd_word_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [bhd_pkg::WORD_W-1:0] data_word;
	logic                       final_record;

	modport source (output valid, output mode, output data_word, output final_record,
		input ready);
	modport sink (input valid, input mode, input data_word, input final_record,
		output ready);
endinterface

interface bhd_dist_if;
	logic                       valid;
	logic                       ready;
	logic [bhd_pkg::DIST_W-1:0] distance;
	logic                       batch_end;

	modport source (output valid, output distance, output batch_end, input ready);
	modport sink (input valid, input distance, input batch_end, output ready);
endinterface

interface bhd_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [bhd_pkg::WPS_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/batch_hamming_distance.sv
// Batch Hamming distance engine, top level. Depends on bhd_pkg, bhd_ifs, bhd_ram.
//
// A query signature of words_per_signature 64-bit words (0 counts as 1, more
// than 16 as 16) is loaded into a 16 x 64 RAM with mode 0 requests; mode 1
// requests stream record words, each XORed with the query word at the same
// position and its set bits added to a running sum. After a record's last
// word one result carries the distance and the final_record mark of that word.
// A query load or a configuration write restarts the record position and the
// sum; a configuration write also restarts query loading. One word is taken
// every cycle: the RAM read is issued when a record word is accepted, popcount
// and accumulate happen in the accumulate stage, and the result is registered
// in an output register that lets new words keep flowing while it waits. The
// only stall is a full output register whose result is not taken while a
// record's last word wants to leave the accumulate stage.
`default_nettype none

module batch_hamming_distance (
	input  wire logic      clk,
	input  wire logic      arst_n,
	bhd_cfg_if.sink        cfg,
	bhd_word_if.sink       word_req,
	bhd_dist_if.source     dist_rsp
);

	logic [bhd_pkg::WPS_W-1:0]  wps_q;
	bhd_pkg::pos_t              qpos_q;
	bhd_pkg::pos_t              rpos_q;
	bhd_pkg::cnt_t              n_words;

	logic                       s1_valid_q;
	bhd_pkg::s1_ctrl_t          s1_q;
	logic [bhd_pkg::WORD_W-1:0] s1_word_s1;
	logic [bhd_pkg::WORD_W-1:0] query_rd;
	logic [bhd_pkg::DIST_W-1:0] sum_q;

	logic                       out_valid_q;
	logic [bhd_pkg::DIST_W-1:0] distance_q;
	logic                       batch_end_q;

	logic                       accept;
	logic                       q_load;
	logic                       r_word;
	logic                       s1_advance;
	bhd_pkg::pos_t              q_addr;
	bhd_pkg::pos_t              r_addr;
	bhd_pkg::cnt_t              q_next;
	bhd_pkg::cnt_t              r_next;
	logic                       r_last;
	logic [bhd_pkg::DIST_W-1:0] sum_base;
	logic [bhd_pkg::DIST_W:0]   sum_wide;
	logic [bhd_pkg::DIST_W-1:0] sum_new;

	// Effective word count, clamped to 1..MAX_WORDS
	always_comb begin
		if (wps_q == '0) begin
			n_words = bhd_pkg::cnt_t'(1);
		end else if (32'(wps_q) > bhd_pkg::MAX_WORDS) begin
			n_words = bhd_pkg::cnt_t'(bhd_pkg::MAX_WORDS);
		end else begin
			n_words = bhd_pkg::cnt_t'(wps_q);
		end
	end

	// Handshakes
	assign cfg.ready      = 1'b1;
	assign s1_advance     = s1_valid_q && (!s1_q.last_word || !out_valid_q || dist_rsp.ready);
	assign word_req.ready = !s1_valid_q || s1_advance;
	assign accept         = word_req.valid && word_req.ready;
	assign q_load         = accept && (word_req.mode == bhd_pkg::MODE_QUERY);
	assign r_word         = accept && (word_req.mode == bhd_pkg::MODE_RECORD);

	// Position arithmetic: wrap a stale position, step, detect end of signature
	always_comb begin
		q_addr = (bhd_pkg::cnt_t'(qpos_q) >= n_words) ? '0 : qpos_q;
		r_addr = (bhd_pkg::cnt_t'(rpos_q) >= n_words) ? '0 : rpos_q;
		q_next = bhd_pkg::cnt_t'(q_addr) + bhd_pkg::cnt_t'(1);
		r_next = bhd_pkg::cnt_t'(r_addr) + bhd_pkg::cnt_t'(1);
		r_last = (r_next >= n_words);
	end

	// Configuration register and word positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wps_q  <= bhd_pkg::WPS_RESET;
			qpos_q <= '0;
			rpos_q <= '0;
		end else if (cfg.valid) begin
			wps_q  <= cfg.data;
			qpos_q <= '0;
			rpos_q <= '0;
		end else if (q_load) begin
			qpos_q <= (q_next >= n_words) ? '0 : q_next[bhd_pkg::POS_W-1:0];
			rpos_q <= '0;
		end else if (r_word) begin
			rpos_q <= r_last ? '0 : r_next[bhd_pkg::POS_W-1:0];
		end
	end

	// Query store
	bhd_ram #(
		.WIDTH (bhd_pkg::WORD_W),
		.DEPTH (bhd_pkg::MAX_WORDS)
	) u_query_ram (
		.clk   (clk),
		.we    (q_load),
		.waddr (q_addr),
		.wdata (word_req.data_word),
		.re    (r_word),
		.raddr (r_addr),
		.rdata (query_rd)
	);

	// Accumulate stage: record word waits here for the query word read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (r_word) begin
			s1_valid_q <= 1'b1;
		end else if (s1_advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (r_word) begin
			s1_word_s1        <= word_req.data_word;
			s1_q.first        <= (r_addr == '0);
			s1_q.last_word    <= r_last;
			s1_q.final_record <= word_req.final_record;
		end
	end

	// XOR, popcount and saturating add
	always_comb begin
		sum_base = s1_q.first ? '0 : sum_q;
		sum_wide = (bhd_pkg::DIST_W+1)'(sum_base)
			+ (bhd_pkg::DIST_W+1)'(bhd_pkg::ones_in_word(s1_word_s1 ^ query_rd));
		sum_new  = sum_wide[bhd_pkg::DIST_W] ? bhd_pkg::DIST_MAX
			: sum_wide[bhd_pkg::DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (s1_advance) begin
			sum_q <= sum_new;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance && s1_q.last_word) begin
			out_valid_q <= 1'b1;
		end else if (dist_rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && s1_q.last_word) begin
			distance_q  <= sum_new;
			batch_end_q <= s1_q.final_record;
		end
	end

	assign dist_rsp.valid     = out_valid_q;
	assign dist_rsp.distance  = distance_q;
	assign dist_rsp.batch_end = batch_end_q;

endmodule

`default_nettype wire

### sv/bhd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data
// that holds until the next read. No dependencies.
`default_nettype none

module bhd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### tb/bhd_checker.sv
// Checker for the batch Hamming distance block: watches the configuration,
// word and distance channels, predicts every distance and compares in order.
// Depends on bhd_pkg and the channel interfaces in bhd_ifs.

module bhd_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	bhd_cfg_if        cfg_mon,
	bhd_word_if       word_mon,
	bhd_dist_if       dist_mon,
	output int        pending,
	output int        errors,
	output int        checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [bhd_pkg::DIST_W-1:0] distance;
		logic                       batch_end;
	} dist_result_t;

	// Expected distances, oldest first
	dist_result_t distance_q[$];

	// Shadow copy of the block's state
	logic [bhd_pkg::WORD_W-1:0] query_shadow [bhd_pkg::MAX_WORDS];
	logic [bhd_pkg::WPS_W-1:0]  words_cfg;
	int unsigned                query_pos;
	int unsigned                record_pos;
	logic [bhd_pkg::DIST_W-1:0] running_sum;

	// Apply one accepted word request; queue a distance when a record completes
	task automatic predict_distance(input logic mode, input logic [bhd_pkg::WORD_W-1:0] word,
		input logic final_mark);
		int unsigned  n;
		int unsigned  total;
		dist_result_t done;
		n = (words_cfg == '0) ? 1 : ((words_cfg > bhd_pkg::MAX_WORDS) ?
			bhd_pkg::MAX_WORDS : int'(words_cfg));
		if (mode == bhd_pkg::MODE_QUERY) begin
			if (query_pos >= n) query_pos = 0;
			query_shadow[query_pos] = word;
			query_pos++;
			if (query_pos >= n) query_pos = 0;
			record_pos  = 0;
			running_sum = '0;
		end else begin
			if (record_pos >= n) record_pos = 0;
			total = running_sum + $countones(word ^ query_shadow[record_pos]);
			if (total > bhd_pkg::DIST_MAX) total = bhd_pkg::DIST_MAX;
			running_sum = bhd_pkg::DIST_W'(total);
			record_pos++;
			if (record_pos >= n) begin
				done.distance  = running_sum;
				done.batch_end = final_mark;
				distance_q     = {distance_q, done};
				record_pos  = 0;
				running_sum = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		dist_result_t want;
		if (!arst_n) begin
			words_cfg   = bhd_pkg::WPS_RESET;
			query_pos   = 0;
			record_pos  = 0;
			running_sum = '0;
			distance_q.delete();
		end else begin
			// register write restarts both positions, keeps the query words
			if (cfg_mon.valid && cfg_mon.ready) begin
				words_cfg   = cfg_mon.data;
				query_pos   = 0;
				record_pos  = 0;
				running_sum = '0;
			end
			if (word_mon.valid && word_mon.ready)
				predict_distance(word_mon.mode, word_mon.data_word, word_mon.final_record);
			// compare the result against the oldest expectation
			if (dist_mon.valid && dist_mon.ready) begin
				if (distance_q.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected distance: expected none, actual %0d/%0b",
						$time, dist_mon.distance, dist_mon.batch_end);
				end else begin
					want = distance_q.pop_front();
					checked++;
					if (dist_mon.distance !== want.distance) begin
						errors++;
						$display("%0t ns: distance mismatch: expected %0d, actual %0d",
							$time, want.distance, dist_mon.distance);
					end
					if (dist_mon.batch_end !== want.batch_end) begin
						errors++;
						$display("%0t ns: batch_end mismatch: expected %0b, actual %0b",
							$time, want.batch_end, dist_mon.batch_end);
					end
				end
			end
		end
		pending = distance_q.size();
	end

endmodule

### tb/tb_batch_hamming_distance.sv
// Testbench top for batch_hamming_distance: clock, reset, word and register
// stimulus with random idling, and the verdict from the checker's error count.
// Depends on bhd_pkg, bhd_ifs, the block itself and bhd_checker.

module tb_batch_hamming_distance;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 1150;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   steady = 1'b0;

	int pending;
	int errors;
	int checked;

	// Stimulus-side view of word count and positions, to keep every read
	// of the query store on a word that was loaded
	int unsigned                   sig_words = 1;
	int unsigned                   load_pos = 0;
	int unsigned                   rec_pos = 0;
	logic [bhd_pkg::MAX_WORDS-1:0] loaded = '0;

	int n_query = 0;
	int n_record = 0;
	int n_settings = 0;

	bhd_cfg_if  cfg_ch ();
	bhd_word_if word_ch ();
	bhd_dist_if dist_ch ();

	batch_hamming_distance DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_ch),
		.word_req (word_ch),
		.dist_rsp (dist_ch)
	);

	bhd_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_mon  (cfg_ch),
		.word_mon (word_ch),
		.dist_mon (dist_ch),
		.pending  (pending),
		.errors   (errors),
		.checked  (checked)
	);

	always #2 clk = ~clk;

	// Result side stalls at random except during the steady stretch
	always @(negedge clk) begin
		dist_ch.ready <= steady || ($urandom_range(0, 99) >= 22);
	end

	// Hard stop if the run hangs
	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [bhd_pkg::WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return bhd_pkg::WORD_W'(1) << $urandom_range(0, bhd_pkg::WORD_W - 1);
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic bit query_complete();
		for (int i = 0; i < sig_words; i++) begin
			if (!loaded[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	// One word request, with random idle cycles ahead of it
	task automatic push_word(input logic mode, input logic [bhd_pkg::WORD_W-1:0] word,
		input logic final_mark);
		while (!steady && $urandom_range(0, 99) < 22) begin
			word_ch.valid <= 1'b0;
			@(negedge clk);
		end
		word_ch.valid        <= 1'b1;
		word_ch.mode         <= mode;
		word_ch.data_word    <= word;
		word_ch.final_record <= final_mark;
		do @(posedge clk); while (!word_ch.ready);
		@(negedge clk);
	endtask

	task automatic load_query_word(input logic [bhd_pkg::WORD_W-1:0] word);
		if (load_pos >= sig_words) load_pos = 0;
		loaded[load_pos] = 1'b1;
		load_pos++;
		if (load_pos >= sig_words) load_pos = 0;
		rec_pos = 0;
		n_query++;
		push_word(bhd_pkg::MODE_QUERY, word, 1'($urandom_range(0, 1)));
	endtask

	task automatic load_query();
		repeat (sig_words) load_query_word(rand_word());
	endtask

	task automatic send_record_word(input logic [bhd_pkg::WORD_W-1:0] word,
		input logic final_mark);
		rec_pos++;
		if (rec_pos >= sig_words) rec_pos = 0;
		n_record++;
		push_word(bhd_pkg::MODE_RECORD, word, final_mark);
	endtask

	// Stop sending and wait until every expected distance has come out
	task automatic drain();
		word_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_words(input logic [bhd_pkg::WPS_W-1:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		sig_words = (value == '0) ? 1 : ((value > bhd_pkg::MAX_WORDS) ?
			bhd_pkg::MAX_WORDS : int'(value));
		load_pos  = 0;
		rec_pos   = 0;
		n_settings++;
	endtask

	initial begin
		int phase_end;
		int k;
		int phase;

		cfg_ch.valid         = 1'b0;
		cfg_ch.data          = '0;
		word_ch.valid        = 1'b0;
		word_ch.mode         = bhd_pkg::MODE_QUERY;
		word_ch.data_word    = '0;
		word_ch.final_record = 1'b0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset count of one: single-word query against single-word records
		load_query_word('0);
		send_record_word('1, 1'b0);
		send_record_word('0, 1'b1);

		// Extra query words wrap around and overwrite word zero
		load_query_word('1);
		load_query_word({32{2'b10}});
		send_record_word({32{2'b01}}, 1'b1);

		// A count of zero behaves as one
		set_words(5'd0);
		send_record_word({32{2'b10}}, 1'b0);

		// Counts above the store depth clamp; all-ones vs all-zeros gives the
		// largest distance, and marks on earlier words must not leak out
		set_words(5'd31);
		repeat (bhd_pkg::MAX_WORDS) load_query_word('1);
		for (int i = 0; i < bhd_pkg::MAX_WORDS; i++) begin
			send_record_word('0, (i == bhd_pkg::MAX_WORDS - 1) ? 1'b1 : 1'(i));
		end

		// Query word in the middle of a record restarts the record
		set_words(5'd2);
		load_query();
		send_record_word(rand_word(), 1'b1);
		load_query_word(rand_word());
		send_record_word(rand_word(), 1'b0);
		send_record_word(rand_word(), 1'b1);

		// Random phases, each with its own word count
		phase = 0;
		phase_end = n_query + n_record + RANDOM_WORDS;
		while (n_query + n_record < phase_end) begin
			steady <= (phase == 2);
			case ($urandom_range(0, 9))
				0: set_words(5'd0);
				1: set_words(5'd31);
				2: set_words(5'd16);
				3, 4: set_words(5'($urandom_range(0, 31)));
				default: set_words(5'($urandom_range(1, 4)));
			endcase
			load_query();
			k = n_query + n_record + ((phase == 2) ? 220 : $urandom_range(60, 140));
			while (n_query + n_record < k) begin
				case ($urandom_range(0, 99)) inside
					[0:74]: begin
						// finish the current record
						if (rec_pos == 0 && !query_complete()) load_query();
						repeat (sig_words - rec_pos)
							send_record_word(rand_word(), 1'($urandom_range(0, 1)));
					end
					[75:84]: begin
						// record fragment, may or may not complete a record
						if (rec_pos == 0 && !query_complete()) load_query();
						repeat ($urandom_range(1, sig_words))
							send_record_word(rand_word(), 1'($urandom_range(0, 1)));
					end
					[85:92]: load_query();
					[93:97]: load_query_word(rand_word());
					default: drain();
				endcase
			end
			phase++;
		end
		steady <= 1'b0;

		drain();
		$display("Covered %0d query and %0d record words over %0d word-count settings,",
			n_query, n_record, n_settings);
		$display("with random idling on both sides and %0d distances compared.", checked);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
